FILE: rtl/evfa_pkg.sv
// Shared constants, register codes and types of the event frame accumulator.
package evfa_pkg;

  // Default geometry and counter width.
  localparam int MAX_COLS_DEF   = 256;
  localparam int MAX_ROWS_DEF   = 256;
  localparam int COUNT_BITS_DEF = 16;

  // Payload widths.
  localparam int COORD_W = 14;
  localparam int PIXEL_W = 16;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd256;

  // Operation codes.
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Control part of one queued command.
  typedef struct packed {
    logic op;
    logic sub;
    logic last;
  } cmd_ctrl_t;

  localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage

FILE: rtl/evfa_if.sv
// Valid/ready channel interfaces for camera events and pixel results.
interface evfa_event_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [evfa_pkg::COORD_W-1:0]  x_coord;
  logic signed [evfa_pkg::COORD_W-1:0]  y_coord;
  logic                                 polarity;

  modport source (output valid, operation, x_coord, y_coord, polarity, input ready);
  modport sink (input valid, operation, x_coord, y_coord, polarity, output ready);
endinterface

interface evfa_pixel_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [evfa_pkg::PIXEL_W-1:0]  pixel_value;
  logic                                 is_normalized;
  logic                                 last_pixel;

  modport source (output valid, pixel_value, is_normalized, last_pixel, input ready);
  modport sink (input valid, pixel_value, is_normalized, last_pixel, output ready);
endinterface

FILE: rtl/evfa_front.sv
// Front end: accepts transactions, rounds and bounds-checks events, walks the readout order.
module evfa_front #(
  parameter int MAX_COLS = evfa_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = evfa_pkg::MAX_ROWS_DEF,
  parameter int ADDR_W   = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  logic                         clk,
  input  logic                         rst,
  evfa_event_if.sink                   events,
  input  logic [evfa_pkg::CFG_W-1:0]   image_width,
  input  logic [evfa_pkg::CFG_W-1:0]   image_height,
  input  logic                         signed_polarity,
  input  logic                         width_we,
  input  logic                         q_full,
  output logic                         push,
  output evfa_pkg::cmd_ctrl_t          push_ctrl,
  output logic [ADDR_W-1:0]            push_addr
);

  localparam int VW  = 14;
  localparam int IW  = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int DCW = $clog2(IW + 1);

  logic [VW-1:0]   eff_w;
  logic [VW-1:0]   eff_h;
  logic [2*VW-1:0] total;
  logic [14:0]     x_mag;
  logic [14:0]     y_mag;
  logic [VW-1:0]   px;
  logic [VW-1:0]   py;
  logic            in_bounds;
  logic            wrap;
  logic [IW-1:0]   cur_idx;
  logic [VW-1:0]   cur_row;
  logic [VW-1:0]   cur_col;
  logic            is_last;
  logic            accept;

  // Readout position, kept both linear and as row and column.
  logic [IW-1:0]   index;
  logic [VW-1:0]   row;
  logic [VW-1:0]   col;

  // Position recompute after a width change (restoring divide, one bit a cycle).
  logic            div_busy;
  logic [DCW-1:0]  div_cnt;
  logic [IW-1:0]   div_src;
  logic [IW-1:0]   div_q;
  logic [VW:0]     div_rem;
  logic [VW:0]     div_sh;
  logic            div_bit;

  // Effective image size: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    eff_w = VW'(image_width);
    if (eff_w == '0) eff_w = VW'(1);
    else if (eff_w > VW'(MAX_COLS)) eff_w = VW'(MAX_COLS);
    eff_h = VW'(image_height);
    if (eff_h == '0) eff_h = VW'(1);
    else if (eff_h > VW'(MAX_ROWS)) eff_h = VW'(MAX_ROWS);
    total = (2*VW)'(eff_w) * (2*VW)'(eff_h);
  end

  // Round Q4 coordinates half away from zero; negative results fall outside.
  always_comb begin
    x_mag = events.x_coord[VW-1] ? (15'd0 - {events.x_coord[VW-1], events.x_coord})
                                  : {1'b0, events.x_coord};
    y_mag = events.y_coord[VW-1] ? (15'd0 - {events.y_coord[VW-1], events.y_coord})
                                  : {1'b0, events.y_coord};
    px = VW'((x_mag + 15'd8) >> 4);
    py = VW'((y_mag + 15'd8) >> 4);
    in_bounds = (!events.x_coord[VW-1] || px == '0) &&
                (!events.y_coord[VW-1] || py == '0) &&
                (px < eff_w) && (py < eff_h);
  end

  // Readout slot, wrapping to the start when the image shrank.
  always_comb begin
    wrap    = (2*VW)'(index) >= total;
    cur_idx = wrap ? '0 : index;
    cur_row = wrap ? '0 : row;
    cur_col = wrap ? '0 : col;
    is_last = (2*VW)'(cur_idx) == (total - (2*VW)'(1));
  end

  assign events.ready = !q_full && !div_busy && !width_we;
  assign accept       = events.valid && events.ready;

  // Command toward the back end.
  always_comb begin
    push_ctrl.op   = events.operation;
    push_ctrl.sub  = signed_polarity && !events.polarity;
    push_ctrl.last = (events.operation == evfa_pkg::OP_READ) && is_last;
    if (events.operation == evfa_pkg::OP_READ) begin
      push_addr = ADDR_W'(cur_row) * ADDR_W'(MAX_COLS) + ADDR_W'(cur_col);
      push      = accept;
    end else begin
      push_addr = ADDR_W'(py) * ADDR_W'(MAX_COLS) + ADDR_W'(px);
      push      = accept && in_bounds;
    end
  end

  assign div_sh  = {div_rem[VW-1:0], div_src[IW-1]};
  assign div_bit = div_sh >= {1'b0, eff_w};

  // Readout position and its recompute.
  always_ff @(posedge clk) begin
    if (rst) begin
      index    <= '0;
      row      <= '0;
      col      <= '0;
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (width_we) begin
      div_busy <= 1'b1;
      div_cnt  <= DCW'(IW);
      div_src  <= index;
      div_q    <= '0;
      div_rem  <= '0;
    end else if (div_busy) begin
      div_src <= {div_src[IW-2:0], 1'b0};
      div_q   <= {div_q[IW-2:0], div_bit};
      div_rem <= div_bit ? (div_sh - {1'b0, eff_w}) : div_sh;
      div_cnt <= div_cnt - DCW'(1);
      if (div_cnt == DCW'(1)) begin
        div_busy <= 1'b0;
        row      <= VW'({div_q[IW-2:0], div_bit});
        col      <= div_bit ? VW'(div_sh - {1'b0, eff_w}) : VW'(div_sh);
      end
    end else if (accept && events.operation == evfa_pkg::OP_READ) begin
      if (is_last) begin
        index <= '0;
        row   <= '0;
        col   <= '0;
      end else begin
        index <= cur_idx + IW'(1);
        if (cur_col == eff_w - VW'(1)) begin
          col <= '0;
          row <= cur_row + VW'(1);
        end else begin
          col <= cur_col + VW'(1);
          row <= cur_row;
        end
      end
    end
  end

endmodule

FILE: rtl/evfa_queue.sv
// Short command queue that decouples the front end from the back end.
module evfa_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = evfa_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [CW-1:0]     count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign rdata = slots[rptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

FILE: rtl/evfa_back.sv
// Back end: pixel count memory, min/max tracking, normalizing divide and result register.
module evfa_back #(
  parameter int MAX_COLS   = evfa_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = evfa_pkg::MAX_ROWS_DEF,
  parameter int COUNT_BITS = evfa_pkg::COUNT_BITS_DEF,
  parameter int ADDR_W     = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  evfa_pkg::cmd_ctrl_t  q_ctrl,
  input  logic [ADDR_W-1:0]    q_addr,
  output logic                 pop,
  input  logic                 normalize_output,
  evfa_pixel_if.source         pixels
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int CB    = COUNT_BITS;
  localparam int NW    = CB + 10;
  localparam int XW    = CB + 17;
  localparam int PW    = evfa_pkg::PIXEL_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic signed [CB:0] CNT_MAX = (CB+1)'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic signed [CB:0] CNT_MIN = -CNT_MAX - (CB+1)'(1);

  logic [2:0]                state;
  logic [ADDR_W-1:0]         clr;
  evfa_pkg::cmd_ctrl_t       ctrl;
  logic [ADDR_W-1:0]         addr;

  logic signed [CB-1:0]      mem [DEPTH];
  logic signed [CB-1:0]      rdata;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [CB-1:0]      mem_wdata;

  logic signed [CB-1:0]      min_count;
  logic signed [CB-1:0]      max_count;
  logic                      max_seen;

  logic signed [CB:0]        sum;
  logic signed [CB-1:0]      v_new;
  logic                      norm;
  logic signed [CB:0]        diff;
  logic signed [CB:0]        span;
  logic signed [XW-1:0]      v_wide;
  logic signed [PW-1:0]      raw;

  logic [NW-1:0]             rem;
  logic [NW-1:0]             dsh;
  logic [8:0]                quo;
  logic [3:0]                step;
  logic                      q_bit;
  logic [8:0]                quo_next;

  logic signed [PW-1:0]      res;
  logic                      res_norm;
  logic                      res_last;
  logic                      out_free;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_free = !pixels.valid || pixels.ready;

  // Saturating update and readout arithmetic on the fetched count.
  always_comb begin
    sum   = (CB+1)'(rdata) + (ctrl.sub ? -(CB+1)'(1) : (CB+1)'(1));
    v_new = CB'(sum);
    if (sum > CNT_MAX) v_new = CB'(CNT_MAX);
    if (sum < CNT_MIN) v_new = CB'(CNT_MIN);
    norm   = normalize_output && max_seen && (max_count > min_count);
    diff   = (CB+1)'(rdata) - (CB+1)'(min_count);
    span   = (CB+1)'(max_count) - (CB+1)'(min_count);
    v_wide = XW'(rdata);
    raw    = PW'(v_wide);
    if (v_wide > $signed(XW'(32767)))  raw = PW'(32767);
    if (v_wide < -$signed(XW'(32768))) raw = -PW'(32767) - PW'(1);
  end

  // One restoring divide step.
  assign q_bit    = rem >= dsh;
  assign quo_next = {quo[7:0], q_bit};

  // Memory write selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr;
    end else if (state == ST_EXEC) begin
      mem_we    = 1'b1;
      mem_wdata = (ctrl.op == evfa_pkg::OP_EVENT) ? v_new : '0;
    end
  end

  // Count memory, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (pop) rdata <= mem[q_addr];
  end

  // Command sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      min_count <= '0;
      max_count <= '0;
      max_seen  <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == ADDR_W'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pop) begin
            ctrl  <= q_ctrl;
            addr  <= q_addr;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (ctrl.op == evfa_pkg::OP_EVENT) begin
            if (!max_seen || v_new > max_count) begin
              max_count <= v_new;
              max_seen  <= 1'b1;
            end
            if (v_new < min_count) min_count <= v_new;
            state <= ST_IDLE;
          end else begin
            res_last <= ctrl.last;
            res_norm <= norm;
            if (ctrl.last) begin
              min_count <= '0;
              max_count <= '0;
              max_seen  <= 1'b0;
            end
            if (norm && diff > 0) begin
              rem   <= NW'(diff) * NW'(510) + NW'(span);
              dsh   <= NW'(span) << 9;
              quo   <= '0;
              step  <= '0;
              state <= ST_DIV;
            end else begin
              res   <= norm ? '0 : raw;
              state <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (q_bit) rem <= rem - dsh;
          dsh  <= dsh >> 1;
          quo  <= quo_next;
          step <= step + 4'd1;
          if (step == 4'd8) begin
            res   <= quo_next[8] ? PW'(255) : PW'(quo_next[7:0]);
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register toward the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      pixels.valid <= 1'b1;
    end else if (pixels.ready) begin
      pixels.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      pixels.pixel_value   <= res;
      pixels.is_normalized <= res_norm;
      pixels.last_pixel    <= res_last;
    end
  end

`ifndef NO_ASSERTIONS
  // The running minimum starts at zero, only falls, and returns to zero after the last pixel is read.
  a_min_nonpos: assert property (@(posedge clk) disable iff (rst) min_count <= 0)
    else $error("min_count above zero");

  // Without a tracked write the maximum stays at its reset value.
  a_max_unseen: assert property (@(posedge clk) disable iff (rst)
    !max_seen |-> max_count == '0)
    else $error("max_count set without max_seen");

  // No command leaves the queue while the clearing pass runs.
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !pop)
    else $error("command taken during clearing pass");

  // A normalized result never exceeds the 8-bit level range.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.is_normalized |-> pixels.pixel_value >= 0 &&
    pixels.pixel_value <= 255)
    else $error("normalized level out of range");
`endif

endmodule

FILE: rtl/event_frame_accumulator.sv
// Event-count image accumulator with Q4 event coordinates and normalized readout.
// After reset a clearing pass zeroes all MAX_COLS*MAX_ROWS count memory entries
// (65536 by default); events queue meanwhile and configuration writes are taken.
// An event occupies the back end for a memory read, then an update; a readout takes
// the read, then the bit-serial 9-step divide for a normalized level above zero.
// A width write recomputes the readout row and column.
// Reset is synchronous and active high; registers return to their listed values.
module event_frame_accumulator #(
  parameter int MAX_COLS   = evfa_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = evfa_pkg::MAX_ROWS_DEF,
  parameter int COUNT_BITS = evfa_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [evfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [evfa_pkg::CFG_W-1:0]       cfg_data,
  evfa_event_if.sink                       events,
  evfa_pixel_if.source                     pixels
);

  localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
  localparam int QW     = evfa_pkg::CTRL_W + ADDR_W;

  logic [evfa_pkg::CFG_W-1:0] image_width;
  logic [evfa_pkg::CFG_W-1:0] image_height;
  logic                       signed_polarity;
  logic                       normalize_output;
  logic                       width_we;

  logic                       push;
  evfa_pkg::cmd_ctrl_t        push_ctrl;
  logic [ADDR_W-1:0]          push_addr;
  logic                       pop;
  logic                       q_full;
  logic                       q_empty;
  logic [QW-1:0]              q_rdata;
  evfa_pkg::cmd_ctrl_t        q_ctrl;
  logic [ADDR_W-1:0]          q_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= evfa_pkg::WIDTH_RST;
      image_height     <= evfa_pkg::HEIGHT_RST;
      signed_polarity  <= 1'b1;
      normalize_output <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        evfa_pkg::REG_WIDTH:     image_width      <= cfg_data;
        evfa_pkg::REG_HEIGHT:    image_height     <= cfg_data;
        evfa_pkg::REG_SIGNED:    signed_polarity  <= cfg_data[0];
        evfa_pkg::REG_NORMALIZE: normalize_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign width_we = cfg_we && (cfg_index == evfa_pkg::REG_WIDTH);

  evfa_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .events          (events),
    .image_width     (image_width),
    .image_height    (image_height),
    .signed_polarity (signed_polarity),
    .width_we        (width_we),
    .q_full          (q_full),
    .push            (push),
    .push_ctrl       (push_ctrl),
    .push_addr       (push_addr)
  );

  evfa_queue #(
    .DATA_W (QW),
    .DEPTH  (evfa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_ctrl, push_addr}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_ctrl = evfa_pkg::cmd_ctrl_t'(q_rdata[QW-1:ADDR_W]);
  assign q_addr = q_rdata[ADDR_W-1:0];

  evfa_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_W     (ADDR_W)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_ctrl           (q_ctrl),
    .q_addr           (q_addr),
    .pop              (pop),
    .normalize_output (normalize_output),
    .pixels           (pixels)
  );

endmodule
